// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Same, on the block's own clock and reset.
`define ASSERT_RST(lbl, prop) \
    `ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// File: sv/tlpi_pkg.sv
package tlpi_pkg;

    localparam int ACC_W  = 40;
    localparam int PROD_W = 34;
    localparam int NODE_W = 8;
    localparam int COL_W  = 13;

    localparam logic [1:0] REQ_HID = 2'd0;
    localparam logic [1:0] REQ_OUT = 2'd1;
    localparam logic [1:0] REQ_PIX = 2'd2;

    localparam logic [63:0] ONE_Q28   = 64'd268435456;
    localparam logic [63:0] LOG2E_Q28 = 64'd387270501;
    localparam logic [63:0] LN2_Q28   = 64'd186065279;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         weight_row;
        logic [9:0]         weight_col;
        logic signed [15:0] weight_value;
        logic [7:0]         pixel_value;
        logic               last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  predicted_class;
        logic [15:0] top_score;
        logic        above_threshold;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIAS,
        S_ACC,
        S_HSIG,
        S_OMAC,
        S_OSIG,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic              take_pix;
        logic              wr_hid;
        logic              wr_out;
        logic              mac_go;
        logic              mac_layer;
        logic              mac_first;
        logic [NODE_W-1:0] row;
        logic [COL_W-1:0]  col;
        logic              sig_go;
        logic              sig_layer;
        logic [NODE_W-1:0] tag;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic mac_busy;
        logic sig_busy;
        logic out_free;
    } t_status;

    // shift-subtract divide, used only for elaboration-time tables
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid of table entry k out of e entries over [-8, 8), Q0.16
    function automatic logic [15:0] sig_entry(input int k, input int e);
        int                 rel;
        logic               neg;
        logic [63:0]        mag;
        logic [63:0]        t;
        logic [63:0]        y;
        logic [63:0]        n;
        logic [63:0]        u;
        logic signed [63:0] sum;
        logic [63:0]        term;
        logic [63:0]        ev;
        logic [63:0]        d;
        logic [63:0]        s;
        rel  = k - (e >> 1);
        neg  = rel < 0;
        mag  = 64'(neg ? -rel : rel);
        t    = udiv64(mag << 32, 64'(e));
        y    = (t * LOG2E_Q28) >> 28;
        n    = y >> 28;
        u    = ((y & (ONE_Q28 - 64'd1)) * LN2_Q28) >> 28;
        sum  = $signed(ONE_Q28);
        term = ONE_Q28;
        for (int i = 1; i <= 12; i++) begin
            term = udiv64((term * u) >> 28, 64'(i));
            if (i[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        ev = (n >= 64'd40) ? 64'd0 : ($unsigned(sum) >> n);
        d  = ONE_Q28 + ev;
        if (neg) begin
            s = udiv64((ev << 16) + (d >> 1), d);
        end else begin
            s = udiv64((64'd1 << 44) + (d >> 1), d);
        end
        return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// File: sv/tlpi_ctrl.sv
module tlpi_ctrl import tlpi_pkg::*; #(
    parameter int IMAGE_PIXELS = 784,
    parameter int HIDDEN_NODES = 64,
    parameter int CLASSES      = 10
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  t_status  i_status,
    output t_cmd     o_cmd
);

    localparam int PI_W  = $clog2(IMAGE_PIXELS + 1);
    localparam int CNT_W = $clog2(HIDDEN_NODES + 2);
    localparam int CL_W  = $clog2(CLASSES);

    t_state            r_state, n_state;
    logic [PI_W-1:0]   r_pi, n_pi;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CL_W-1:0]   r_cls, n_cls;
    logic              r_last, n_last;
    logic              w_acc;
    logic              w_pix;

    assign w_acc = i_in_valid && (r_state == S_IDLE);
    assign w_pix = w_acc && (i_in_data.req_type == REQ_PIX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pi    <= '0;
            r_cnt   <= '0;
            r_cls   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pi    <= n_pi;
            r_cnt   <= n_cnt;
            r_cls   <= n_cls;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pi    = r_pi;
        n_cnt   = r_cnt;
        n_cls   = r_cls;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_pix) begin
                    n_last = i_in_data.last_pixel;
                    if (r_pi == '0) begin
                        n_state = S_BIAS;
                    end else if (r_pi < PI_W'(IMAGE_PIXELS)) begin
                        n_state = S_ACC;
                    end else if (i_in_data.last_pixel) begin
                        n_pi    = '0;
                        n_state = S_HSIG;
                    end
                end
            end
            S_BIAS: begin
                if (r_cnt < CNT_W'(HIDDEN_NODES)) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!i_status.mac_busy) begin
                    n_cnt   = '0;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_cnt < CNT_W'(HIDDEN_NODES)) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!i_status.mac_busy) begin
                    n_cnt = '0;
                    if (r_last) begin
                        n_pi    = '0;
                        n_state = S_HSIG;
                    end else begin
                        n_pi    = r_pi + 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_HSIG: begin
                if (r_cnt < CNT_W'(HIDDEN_NODES)) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!i_status.sig_busy) begin
                    n_cnt   = '0;
                    n_cls   = '0;
                    n_state = S_OMAC;
                end
            end
            S_OMAC: begin
                if (r_cnt <= CNT_W'(HIDDEN_NODES)) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!i_status.mac_busy) begin
                    n_cnt   = '0;
                    n_state = S_OSIG;
                end
            end
            S_OSIG: begin
                if (r_cnt == '0) begin
                    n_cnt = CNT_W'(1);
                end else if (!i_status.sig_busy) begin
                    n_cnt = '0;
                    if (r_cls == CL_W'(CLASSES - 1)) begin
                        n_state = S_RESULT;
                    end else begin
                        n_cls   = r_cls + 1'b1;
                        n_state = S_OMAC;
                    end
                end
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.take_pix = w_pix;
                o_cmd.wr_hid   = w_acc && (i_in_data.req_type == REQ_HID)
                                 && (9'(i_in_data.weight_row) < 9'(HIDDEN_NODES))
                                 && (COL_W'(i_in_data.weight_col) <= COL_W'(IMAGE_PIXELS));
                o_cmd.wr_out   = w_acc && (i_in_data.req_type == REQ_OUT)
                                 && (9'(i_in_data.weight_row) < 9'(CLASSES))
                                 && (COL_W'(i_in_data.weight_col) <= COL_W'(HIDDEN_NODES));
            end
            S_BIAS: begin
                o_cmd.mac_go    = r_cnt < CNT_W'(HIDDEN_NODES);
                o_cmd.mac_first = 1'b1;
                o_cmd.row       = NODE_W'(r_cnt);
            end
            S_ACC: begin
                o_cmd.mac_go = r_cnt < CNT_W'(HIDDEN_NODES);
                o_cmd.row    = NODE_W'(r_cnt);
                o_cmd.col    = COL_W'(r_pi) + 1'b1;
            end
            S_HSIG: begin
                o_cmd.sig_go = r_cnt < CNT_W'(HIDDEN_NODES);
                o_cmd.tag    = NODE_W'(r_cnt);
            end
            S_OMAC: begin
                o_cmd.mac_go    = r_cnt <= CNT_W'(HIDDEN_NODES);
                o_cmd.mac_layer = 1'b1;
                o_cmd.mac_first = r_cnt == '0;
                o_cmd.row       = NODE_W'(r_cls);
                o_cmd.col       = COL_W'(r_cnt);
            end
            S_OSIG: begin
                o_cmd.sig_go    = r_cnt == '0;
                o_cmd.sig_layer = 1'b1;
                o_cmd.tag       = NODE_W'(r_cls);
            end
            S_RESULT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/tlpi_datapath.sv
module tlpi_datapath import tlpi_pkg::*; #(
    parameter int IMAGE_PIXELS    = 784,
    parameter int HIDDEN_NODES    = 64,
    parameter int CLASSES         = 10,
    parameter int SIGMOID_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  t_in_item    i_in_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int HW_DEPTH = HIDDEN_NODES * (IMAGE_PIXELS + 1);
    localparam int OW_DEPTH = CLASSES * (HIDDEN_NODES + 1);
    localparam int HW_AW    = (HW_DEPTH > 1) ? $clog2(HW_DEPTH) : 1;
    localparam int OW_AW    = $clog2(OW_DEPTH);
    localparam int H_AW     = (HIDDEN_NODES > 1) ? $clog2(HIDDEN_NODES) : 1;
    localparam int EI       = $clog2(SIGMOID_ENTRIES);

    // memories
    logic signed [15:0]      r_hw_mem  [HW_DEPTH];
    logic signed [15:0]      r_ow_mem  [OW_DEPTH];
    logic signed [ACC_W-1:0] r_sum_mem [HIDDEN_NODES];
    logic [15:0]             r_act_mem [HIDDEN_NODES];
    logic [15:0]             w_rom     [SIGMOID_ENTRIES];

    logic signed [15:0]      r_hw_rd;
    logic signed [15:0]      r_ow_rd;
    logic signed [ACC_W-1:0] r_sum_rd;
    logic [15:0]             r_act_rd;

    logic [HW_AW-1:0] w_hw_wa, w_hw_ra;
    logic [OW_AW-1:0] w_ow_wa, w_ow_ra;
    logic [H_AW-1:0]  w_sum_ra, w_act_ra;

    logic [15:0] r_pix;
    logic [15:0] r_thr;

    // MAC pipe
    logic                     r_m1_v, r_m1_layer, r_m1_first;
    logic [H_AW-1:0]          r_m1_row;
    logic                     r_m2_v, r_m2_layer, r_m2_first;
    logic [H_AW-1:0]          r_m2_row;
    logic signed [PROD_W-1:0] r_m2_prod;
    logic signed [ACC_W-1:0]  r_m2_sum;
    logic signed [ACC_W-1:0]  r_oacc;
    logic signed [15:0]       w_m_w;
    logic [16:0]              w_m_op;
    logic signed [ACC_W-1:0]  w_m_base;
    logic signed [ACC_W:0]    w_m_sum;
    logic signed [ACC_W-1:0]  w_m_res;

    // sigmoid pipe
    logic                    r_s1_v, r_s1_layer;
    logic [NODE_W-1:0]       r_s1_tag;
    logic                    r_s2_v, r_s2_layer;
    logic [NODE_W-1:0]       r_s2_tag;
    logic [EI-1:0]           r_s2_idx;
    logic                    r_s3_v, r_s3_layer;
    logic [NODE_W-1:0]       r_s3_tag;
    logic [15:0]             r_s3_sig;
    logic signed [ACC_W-1:0] w_s_val;
    logic signed [53:0]      w_s_prod;
    logic signed [21:0]      w_s_q;
    logic [EI-1:0]           w_s_idx;

    logic [15:0] r_best;
    logic [3:0]  r_bcls;
    logic        r_ov;
    t_out_item   r_odata;

    for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
        localparam logic [15:0] SigVal = sig_entry(k, SIGMOID_ENTRIES);
        assign w_rom[k] = SigVal;
    end

    assign w_hw_wa = HW_AW'(HW_AW'(i_in_data.weight_row) * HW_AW'(IMAGE_PIXELS + 1)
                     + HW_AW'(i_in_data.weight_col));
    assign w_ow_wa = OW_AW'(OW_AW'(i_in_data.weight_row) * OW_AW'(HIDDEN_NODES + 1)
                     + OW_AW'(i_in_data.weight_col));
    assign w_hw_ra = HW_AW'(HW_AW'(i_cmd.row) * HW_AW'(IMAGE_PIXELS + 1)
                     + HW_AW'(i_cmd.col));
    assign w_ow_ra = OW_AW'(OW_AW'(i_cmd.row) * OW_AW'(HIDDEN_NODES + 1)
                     + OW_AW'(i_cmd.col));
    assign w_sum_ra = i_cmd.mac_go ? i_cmd.row[H_AW-1:0] : i_cmd.tag[H_AW-1:0];
    assign w_act_ra = H_AW'(i_cmd.col - 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_hid) begin
            r_hw_mem[w_hw_wa] <= i_in_data.weight_value;
        end
        r_hw_rd <= r_hw_mem[w_hw_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_out) begin
            r_ow_mem[w_ow_wa] <= i_in_data.weight_value;
        end
        r_ow_rd <= r_ow_mem[w_ow_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_m2_v && !r_m2_layer) begin
            r_sum_mem[r_m2_row] <= w_m_res;
        end
        r_sum_rd <= r_sum_mem[w_sum_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_v && !r_s3_layer) begin
            r_act_mem[r_s3_tag[H_AW-1:0]] <= r_s3_sig;
        end
        r_act_rd <= r_act_mem[w_act_ra];
    end

    // MAC datapath
    assign w_m_w  = r_m1_layer ? r_ow_rd : r_hw_rd;
    assign w_m_op = r_m1_first ? 17'h10000 : {1'b0, (r_m1_layer ? r_act_rd : r_pix)};
    assign w_m_base = r_m2_first ? '0 : (r_m2_layer ? r_oacc : r_m2_sum);
    assign w_m_sum  = (ACC_W + 1)'(w_m_base) + (ACC_W + 1)'(r_m2_prod);
    always_comb begin
        if (w_m_sum[ACC_W] != w_m_sum[ACC_W-1]) begin
            w_m_res = w_m_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                     : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            w_m_res = w_m_sum[ACC_W-1:0];
        end
    end

    // sigmoid index: floor(sum * entries / 2^32) + entries/2, clamped
    assign w_s_val  = r_s1_layer ? r_oacc : r_sum_rd;
    assign w_s_prod = 54'(w_s_val) * $signed(54'(SIGMOID_ENTRIES));
    assign w_s_q    = 22'(w_s_prod >>> 32) + 22'(SIGMOID_ENTRIES / 2);
    always_comb begin
        if (w_s_q < 0) begin
            w_s_idx = '0;
        end else if (w_s_q > $signed(22'(SIGMOID_ENTRIES - 1))) begin
            w_s_idx = EI'(SIGMOID_ENTRIES - 1);
        end else begin
            w_s_idx = w_s_q[EI-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_ov   <= 1'b0;
            r_thr  <= 16'd32768;
        end else begin
            r_m1_v <= i_cmd.mac_go;
            r_m2_v <= r_m1_v;
            r_s1_v <= i_cmd.sig_go;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pix) begin
            r_pix <= {i_in_data.pixel_value, i_in_data.pixel_value};
        end
        r_m1_layer <= i_cmd.mac_layer;
        r_m1_first <= i_cmd.mac_first;
        r_m1_row   <= i_cmd.row[H_AW-1:0];
        r_m2_layer <= r_m1_layer;
        r_m2_first <= r_m1_first;
        r_m2_row   <= r_m1_row;
        r_m2_prod  <= PROD_W'(w_m_w * $signed({1'b0, w_m_op}));
        r_m2_sum   <= r_sum_rd;
        if (r_m2_v && r_m2_layer) begin
            r_oacc <= w_m_res;
        end
        r_s1_layer <= i_cmd.sig_layer;
        r_s1_tag   <= i_cmd.tag;
        r_s2_layer <= r_s1_layer;
        r_s2_tag   <= r_s1_tag;
        r_s2_idx   <= w_s_idx;
        r_s3_layer <= r_s2_layer;
        r_s3_tag   <= r_s2_tag;
        r_s3_sig   <= w_rom[r_s2_idx];
        if (r_s3_v && r_s3_layer && ((r_s3_tag == '0) || (r_s3_sig > r_best))) begin
            r_best <= r_s3_sig;
            r_bcls <= r_s3_tag[3:0];
        end
        if (i_cmd.emit) begin
            r_odata.predicted_class <= r_bcls;
            r_odata.top_score       <= r_best;
            r_odata.above_threshold <= r_best > r_thr;
        end
    end

    assign o_status.mac_busy = r_m1_v || r_m2_v;
    assign o_status.sig_busy = r_s1_v || r_s2_v || r_s3_v;
    assign o_status.out_free = !r_ov || i_out_ready;
    assign o_out_valid       = r_ov;
    assign o_out_data        = r_odata;

endmodule

// File: sv/two_layer_perceptron_inference_core.sv
// Two-layer sigmoid perceptron inference. A weight beat (hidden or output matrix, column 0
// is the bias) is written to its memory; weight memories are not cleared and must be loaded
// before use. A pixel beat runs one MAC pipe over every hidden accumulator in turn, and the
// first pixel of an image loads the biases the same way before that. The pixel marked last
// then runs the hidden sigmoid lookups and the output layer, all through the same MAC and
// sigmoid ROM, before the result beat is offered. The result sits in an output register.
module two_layer_perceptron_inference_core import tlpi_pkg::*; #(
    parameter int IMAGE_PIXELS    = 784,
    parameter int HIDDEN_NODES    = 64,
    parameter int CLASSES         = 10,
    parameter int SIGMOID_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    t_cmd    w_cmd;
    t_status w_status;

    tlpi_ctrl #(
        .IMAGE_PIXELS(IMAGE_PIXELS),
        .HIDDEN_NODES(HIDDEN_NODES),
        .CLASSES     (CLASSES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data (i_in_data),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    tlpi_datapath #(
        .IMAGE_PIXELS   (IMAGE_PIXELS),
        .HIDDEN_NODES   (HIDDEN_NODES),
        .CLASSES        (CLASSES),
        .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

// File: sv/tlpi_checker.sv
`include "assert_macros.svh"

module tlpi_checker import tlpi_pkg::*; #(
    parameter int CLASSES = 10
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // result beat holds until taken
    `ASSERT_RST(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid)

    // weight and unused beats never stall the input
    `ASSERT_RST(a_wr_no_stall, i_in_valid && o_in_ready && (i_in_data.req_type != REQ_PIX) |=> o_in_ready)

    // class index in range
    `ASSERT_RST(a_class_range, o_out_valid |-> (5'(o_out_data.predicted_class) < 5'(CLASSES)))

endmodule

bind two_layer_perceptron_inference_core tlpi_checker #(.CLASSES(CLASSES)) u_chk (.*);
